// ===== hw/rtl/fov_point_culler_unit_macros.svh =====
// Assertion macros used by the field-of-view culler RTL
`ifndef FOV_POINT_CULLER_UNIT_MACROS_SVH
`define FOV_POINT_CULLER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fov culler check failed");

// Next-cycle implication, checked outside reset
`define FPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fov culler check failed");

`endif

// ===== hw/rtl/fpc_pkg.sv =====
// Constants, register codes and arctangent table for the field-of-view culler
`timescale 1ns / 1ps
package fpc_pkg;

    localparam int COORD_BITS_DEF    = 32;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // internal angle: 2^32 units per turn, signed with headroom
    localparam int ZW  = 34;
    localparam int CFG_IDX_W = 3;
    localparam int ATAN_LEN  = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_HFOV     = 3'd6,
        REG_VFOV     = 3'd7
    } cfg_reg_t;

    localparam logic signed [ZW-1:0] TURN_HALF = 34'sd2147483648;

    // atan(2^-i), 2^32 units per turn
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    function automatic logic signed [ZW-1:0] atan_step(input int i);
        return $signed({2'b00, ATAN_TAB[i]});
    endfunction

endpackage

// ===== hw/rtl/fpc_stream_if.sv =====
// Valid/ready channel interfaces for points in and culled points out
`timescale 1ns / 1ps
interface fpc_in_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pt_x;
    logic signed [COORD_BITS-1:0] pt_y;
    logic signed [COORD_BITS-1:0] pt_z;
    logic                         in_last;
    modport source (output valid, pt_x, pt_y, pt_z, in_last, input ready);
    modport sink   (input valid, pt_x, pt_y, pt_z, in_last, output ready);
endinterface

interface fpc_out_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic                         visible;
    logic                         out_last;
    modport source (output valid, out_x, out_y, out_z, visible, out_last, input ready);
    modport sink   (input valid, out_x, out_y, out_z, visible, out_last, output ready);
endinterface

// ===== hw/rtl/fov_point_culler_unit.sv =====
// Field-of-view point culler: offset, four CORDIC pipelines, angle window test
// Stages: offset, half-plane fold, CORDIC iterations, rounding, window test.
// Throughput: one point per cycle while out_ch is ready; four unrolled CORDIC
// vectoring pipelines, one iteration per stage, set the depth. Each stage
// advances when empty or when the stage after it moves, so bubbles collapse
// under output stall. Reset empties the pipeline and loads origin 0,
// direction (1.0,0,0), both fov a quarter turn.
`timescale 1ns / 1ps
`include "fov_point_culler_unit_macros.svh"
module fov_point_culler_unit
    import fpc_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    fpc_in_if.sink                in_ch,
    fpc_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [((COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS)-1:0] cfg_data
);

    localparam int W   = COORD_BITS + 3;
    localparam int S   = 32 - ANGLE_BITS;
    localparam int AW  = ZW - S;
    localparam int N   = CORDIC_STAGES;
    localparam int NS  = N + 3;           // index of output stage
    localparam int RS  = N + 2;           // rounding stage
    localparam logic signed [ZW-1:0] RND = ZW'(64'sd1 <<< (S - 1));

    // configuration registers
    logic signed [COORD_BITS-1:0] origin_reg [3];
    logic signed [COORD_BITS-1:0] dir_reg    [3];
    logic [ANGLE_BITS-1:0]        hfov_reg;
    logic [ANGLE_BITS-1:0]        vfov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= COORD_BITS'(65536);
            dir_reg[1]    <= '0;
            dir_reg[2]    <= '0;
            hfov_reg      <= ANGLE_BITS'(16384);
            vfov_reg      <= ANGLE_BITS'(16384);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X: origin_reg[0] <= cfg_data[COORD_BITS-1:0];
                REG_ORIGIN_Y: origin_reg[1] <= cfg_data[COORD_BITS-1:0];
                REG_ORIGIN_Z: origin_reg[2] <= cfg_data[COORD_BITS-1:0];
                REG_DIR_X:    dir_reg[0]    <= cfg_data[COORD_BITS-1:0];
                REG_DIR_Y:    dir_reg[1]    <= cfg_data[COORD_BITS-1:0];
                REG_DIR_Z:    dir_reg[2]    <= cfg_data[COORD_BITS-1:0];
                REG_HFOV:     hfov_reg      <= cfg_data[ANGLE_BITS-1:0];
                REG_VFOV:     vfov_reg      <= cfg_data[ANGLE_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // stage valids and per-stage advance
    logic [NS:0] val_reg;
    logic [NS:0] en;

    always_comb
    begin
        en[NS] = !val_reg[NS] || out_ch.ready;
        for (int s = NS - 1; s >= 0; s--)
        begin
            en[s] = !val_reg[s] || en[s+1];
        end
    end

    assign in_ch.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                val_reg[0] <= in_ch.valid;
            end
            for (int s = 1; s <= NS; s++)
            begin
                if (en[s])
                begin
                    val_reg[s] <= val_reg[s-1];
                end
            end
        end
    end

    // pass-through payload travels with the valid bits
    logic signed [COORD_BITS-1:0] px_reg [NS+1];
    logic signed [COORD_BITS-1:0] py_reg [NS+1];
    logic signed [COORD_BITS-1:0] pz_reg [NS+1];
    logic                         last_reg [NS+1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg[0]   <= in_ch.pt_x;
            py_reg[0]   <= in_ch.pt_y;
            pz_reg[0]   <= in_ch.pt_z;
            last_reg[0] <= in_ch.in_last;
        end
        for (int s = 1; s <= NS; s++)
        begin
            if (en[s])
            begin
                px_reg[s]   <= px_reg[s-1];
                py_reg[s]   <= py_reg[s-1];
                pz_reg[s]   <= pz_reg[s-1];
                last_reg[s] <= last_reg[s-1];
            end
        end
    end

    // stage 0: subtract origin with saturation
    logic signed [COORD_BITS-1:0] off_reg [3];
    logic signed [COORD_BITS-1:0] dcp_reg [3];
    logic signed [COORD_BITS-1:0] pin [3];
    logic signed [COORD_BITS:0]   dsum [3];
    logic signed [COORD_BITS-1:0] dsat [3];

    assign pin[0] = in_ch.pt_x;
    assign pin[1] = in_ch.pt_y;
    assign pin[2] = in_ch.pt_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dsum[k] = {pin[k][COORD_BITS-1], pin[k]}
                    - {origin_reg[k][COORD_BITS-1], origin_reg[k]};
            if (dsum[k][COORD_BITS] != dsum[k][COORD_BITS-1])
            begin
                dsat[k] = dsum[k][COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                              : {1'b0, {(COORD_BITS-1){1'b1}}};
            end
            else
            begin
                dsat[k] = dsum[k][COORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                off_reg[k] <= dsat[k];
                dcp_reg[k] <= dir_reg[k];
            end
        end
    end

    // CORDIC state: vector 0 point horiz, 1 point vert, 2 dir horiz, 3 dir vert
    logic signed [W-1:0]  cx_reg [1:N+1][4];
    logic signed [W-1:0]  cy_reg [1:N+1][4];
    logic signed [ZW-1:0] cz_reg [1:N+1][4];
    logic                 zr_reg [1:N+1][4];

    // stage 1: fold left half-plane onto the right
    logic signed [W-1:0] vx [4];
    logic signed [W-1:0] vy [4];

    always_comb
    begin
        vx[0] = W'(off_reg[0]);
        vy[0] = W'(off_reg[1]);
        vx[1] = W'(off_reg[2]);
        vy[1] = W'(off_reg[1]);
        vx[2] = W'(dcp_reg[0]);
        vy[2] = W'(dcp_reg[1]);
        vx[3] = W'(dcp_reg[2]);
        vy[3] = W'(dcp_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int j = 0; j < 4; j++)
            begin
                zr_reg[1][j] <= (vx[j] == '0) && (vy[j] == '0);
                if (vx[j][W-1])
                begin
                    cx_reg[1][j] <= -vx[j];
                    cy_reg[1][j] <= -vy[j];
                    cz_reg[1][j] <= vy[j][W-1] ? -TURN_HALF : TURN_HALF;
                end
                else
                begin
                    cx_reg[1][j] <= vx[j];
                    cy_reg[1][j] <= vy[j];
                    cz_reg[1][j] <= '0;
                end
            end
        end
    end

    // one vectoring iteration per stage
    for (genvar k = 0; k < N; k++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (en[k+2])
            begin
                for (int j = 0; j < 4; j++)
                begin
                    zr_reg[k+2][j] <= zr_reg[k+1][j];
                    if (!cy_reg[k+1][j][W-1])
                    begin
                        cx_reg[k+2][j] <= cx_reg[k+1][j] + (cy_reg[k+1][j] >>> k);
                        cy_reg[k+2][j] <= cy_reg[k+1][j] - (cx_reg[k+1][j] >>> k);
                        cz_reg[k+2][j] <= cz_reg[k+1][j] + atan_step(k);
                    end
                    else
                    begin
                        cx_reg[k+2][j] <= cx_reg[k+1][j] - (cy_reg[k+1][j] >>> k);
                        cy_reg[k+2][j] <= cy_reg[k+1][j] + (cx_reg[k+1][j] >>> k);
                        cz_reg[k+2][j] <= cz_reg[k+1][j] - atan_step(k);
                    end
                end
            end
        end
    end

    // clamp to half a turn and round to the output angle width
    logic signed [AW-1:0] ang_reg [4];
    logic signed [ZW-1:0] zcl [4];
    logic signed [ZW-1:0] zrd [4];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            if (cz_reg[N+1][j] > TURN_HALF)
            begin
                zcl[j] = TURN_HALF;
            end
            else if (cz_reg[N+1][j] < -TURN_HALF)
            begin
                zcl[j] = -TURN_HALF;
            end
            else
            begin
                zcl[j] = cz_reg[N+1][j];
            end
            zrd[j] = (zcl[j] + RND) >>> S;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[RS])
        begin
            for (int j = 0; j < 4; j++)
            begin
                ang_reg[j] <= zr_reg[N+1][j] ? '0 : zrd[j][AW-1:0];
            end
        end
    end

    // window test on the angle differences
    logic signed [AW:0] dh;
    logic signed [AW:0] dv;
    logic [AW:0]        ah;
    logic [AW:0]        av;
    logic               vis;
    logic               vis_reg;

    always_comb
    begin
        dh  = {ang_reg[0][AW-1], ang_reg[0]} - {ang_reg[2][AW-1], ang_reg[2]};
        dv  = {ang_reg[1][AW-1], ang_reg[1]} - {ang_reg[3][AW-1], ang_reg[3]};
        ah  = dh[AW] ? -dh : dh;
        av  = dv[AW] ? -dv : dv;
        vis = ({ah, 1'b0} <= (AW+2)'(hfov_reg)) && ({av, 1'b0} <= (AW+2)'(vfov_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en[NS])
        begin
            vis_reg <= vis;
        end
    end

    // output drive
    assign out_ch.valid    = val_reg[NS];
    assign out_ch.out_x    = px_reg[NS];
    assign out_ch.out_y    = py_reg[NS];
    assign out_ch.out_z    = pz_reg[NS];
    assign out_ch.out_last = last_reg[NS];
    assign out_ch.visible  = vis_reg;

    // checks
    `FPC_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_ch.valid && in_ch.ready, val_reg[0])
    `FPC_ASSERT_NOW(a_empty_takes, clk, rst_n, !val_reg[0], in_ch.ready)
    `FPC_ASSERT_NEXT(a_stall_keeps, clk, rst_n, val_reg[NS] && !out_ch.ready, val_reg[NS])

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the field-of-view point culler
`timescale 1ns / 1ps
module testbench;
    import fpc_pkg::*;

    localparam longint HALF_TURN = 64'sd2147483648;
    localparam int     DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
        logic               visible;
    } culled_point_t;

    // Holds the register copy, predicts visibility and compares results
    class cull_scoreboard;
        logic signed [31:0] origin [3];
        logic signed [31:0] dir [3];
        logic [15:0]        hfov;
        logic [15:0]        vfov;
        culled_point_t      pending_q [$];
        int                 errors;

        function new();
            origin = '{0, 0, 0};
            dir    = '{32'sd65536, 0, 0};
            hfov   = 16'd16384;
            vfov   = 16'd16384;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] data);
            case (idx)
                REG_ORIGIN_X: origin[0] = data;
                REG_ORIGIN_Y: origin[1] = data;
                REG_ORIGIN_Z: origin[2] = data;
                REG_DIR_X:    dir[0] = data;
                REG_DIR_Y:    dir[1] = data;
                REG_DIR_Z:    dir[2] = data;
                REG_HFOV:     hfov = data[15:0];
                REG_VFOV:     vfov = data[15:0];
                default:      ;
            endcase
        endfunction

        // CORDIC vectoring, no gain correction, rounded to 16-bit binary angle
        function longint bin_angle(longint y, longint x);
            longint z;
            longint dx;
            longint dy;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                z = (y >= 0) ? HALF_TURN : -HALF_TURN;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0)
                begin
                    x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
                end
                else
                begin
                    x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
                end
            end
            if (z > HALF_TURN) z = HALF_TURN;
            if (z < -HALF_TURN) z = -HALF_TURN;
            return (z + 64'sd32768) >>> 16;
        endfunction

        function bit in_window(longint p, longint d, logic [15:0] fov);
            longint diff;
            diff = p - d;
            if (diff < 0) diff = -diff;
            return (2 * diff) <= longint'(fov);
        endfunction

        function void note_point(culled_point_t pt);
            longint off [3];
            longint pos [3];
            culled_point_t exp_pt;
            pos = '{longint'(pt.x), longint'(pt.y), longint'(pt.z)};
            // saturate point minus origin to the 32-bit signed range
            for (int k = 0; k < 3; k++)
            begin
                off[k] = pos[k] - longint'(origin[k]);
                if (off[k] > 64'sd2147483647) off[k] = 64'sd2147483647;
                if (off[k] < -64'sd2147483648) off[k] = -64'sd2147483648;
            end
            exp_pt = pt;
            exp_pt.visible =
                in_window(bin_angle(off[1], off[0]),
                          bin_angle(longint'(dir[1]), longint'(dir[0])), hfov) &&
                in_window(bin_angle(off[1], off[2]),
                          bin_angle(longint'(dir[1]), longint'(dir[2])), vfov);
            pending_q.push_back(exp_pt);
        endfunction

        function void check_result(culled_point_t got);
            culled_point_t exp_pt;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result item: x %h y %h z %h", got.x, got.y, got.z);
                errors++;
                return;
            end
            exp_pt = pending_q.pop_front();
            if (got.x !== exp_pt.x)
            begin
                $error("out_x: expected %h, got %h", exp_pt.x, got.x);
                errors++;
            end
            if (got.y !== exp_pt.y)
            begin
                $error("out_y: expected %h, got %h", exp_pt.y, got.y);
                errors++;
            end
            if (got.z !== exp_pt.z)
            begin
                $error("out_z: expected %h, got %h", exp_pt.z, got.z);
                errors++;
            end
            if (got.visible !== exp_pt.visible)
            begin
                $error("visible: expected %b, got %b", exp_pt.visible, got.visible);
                errors++;
            end
            if (got.last !== exp_pt.last)
            begin
                $error("out_last: expected %b, got %b", exp_pt.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    bit          quiet;

    fpc_in_if  #(.COORD_BITS(32)) pt_ch ();
    fpc_out_if #(.COORD_BITS(32)) res_ch ();

    cull_scoreboard board = new();

    fov_point_culler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (pt_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Mostly short gaps, a few long ones; none in quiet stretches
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            2: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom_range(0, 16) - 8;
        endcase
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.set_reg(idx, data);
        @(posedge clk);
    endtask

    // Write all eight registers, upper fov bits random to check they drop
    task automatic load_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                               logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                               logic [15:0] hf, logic [15:0] vf);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, dx);
        write_reg(REG_DIR_Y, dy);
        write_reg(REG_DIR_Z, dz);
        write_reg(REG_HFOV, {16'($urandom), hf});
        write_reg(REG_VFOV, {16'($urandom), vf});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
        culled_point_t pt;
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            pt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_ch.valid   <= 1'b1;
        pt_ch.pt_x    <= x;
        pt_ch.pt_y    <= y;
        pt_ch.pt_z    <= z;
        pt_ch.in_last <= last;
        @(posedge clk);
        while (!pt_ch.ready) @(posedge clk);
        pt.x = x; pt.y = y; pt.z = z; pt.last = last; pt.visible = 1'b0;
        board.note_point(pt);
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
            send_point(pick_coord(), pick_coord(), pick_coord(), ($urandom_range(0, 15) == 0));
    endtask

    // Drop valid and wait for the pipeline to empty
    task automatic drain();
        pt_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: check accepted items, stall at random
    initial
    begin
        culled_point_t got;
        int stall;
        stall = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                got.x = res_ch.out_x;
                got.y = res_ch.out_y;
                got.z = res_ch.out_z;
                got.visible = res_ch.visible;
                got.last = res_ch.out_last;
                board.check_result(got);
            end
            if (stall > 0)
            begin
                stall--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = gap_len();
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        quiet         = 1'b0;
        pt_ch.valid   = 1'b0;
        pt_ch.pt_x    = '0;
        pt_ch.pt_y    = '0;
        pt_ch.pt_z    = '0;
        pt_ch.in_last = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points under reset settings
        send_point(32'h0, 32'h0, 32'h0, 1'b0);
        send_point(32'hffff_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h0, 32'h0, 32'hfffb_0000, 1'b0);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0);
        send_point(32'h0001_0000, 32'hffff_0000, 32'h0001_0000, 1'b0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        send_point(32'h8000_0000, 32'h1, 32'h7fff_ffff, 1'b0);
        send_point(32'h8000_0000, 32'hffff_ffff, 32'h1, 1'b1);
        drain();

        // Extreme origin forces saturation; zero direction; widest fov
        load_config(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                    32'h0, 32'h0, 32'h0, 16'hffff, 16'hffff);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 1'b1);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
        send_random(120);
        drain();

        // Narrowest fov with origin at the opposite extreme
        load_config(32'h7fff_ffff, 32'h8000_0000, 32'h1,
                    32'hffff_0000, 32'h0, 32'h0, 16'h0, 16'h0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h1, 1'b0);
        send_point(32'h0, 32'h8000_0000, 32'h1, 1'b1);
        send_random(60);
        drain();

        // Random settings; alternate quiet stretches with gaps
        for (int ph = 0; ph < 6; ph++)
        begin
            quiet = (ph % 3 == 1);
            load_config(pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord(), pick_coord(),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            send_random(170);
            drain();
        end
        quiet = 1'b0;

        if (board.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Hang guard
    initial
    begin
        #20ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
